### hdl/qhd_pkg.sv
// Shared types and constants of the quaternary Huffman decoder.
`default_nettype none

package qhd_pkg;

  // Default number of inner nodes in the decoding tree.
  localparam int INNER_NODES_DEF = 85;

  // Field widths.
  localparam int NODE_W      = 7;
  localparam int DIGIT_W     = 2;
  localparam int SYM_W       = 8;
  localparam int CNT_W       = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Request kinds carried on in_tuser.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // One node table entry as stored in the RAM.
  typedef struct packed {
    logic              leaf;
    logic [NODE_W-1:0] next;
    logic [SYM_W-1:0]  value;
  } entry_t;

  // Input tdata layout, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]         pad;
    logic [SYM_W-1:0]   data_byte;
    logic [SYM_W-1:0]   entry_value;
    logic [NODE_W-1:0]  entry_next;
    logic               entry_is_leaf;
    logic [DIGIT_W-1:0] entry_digit;
    logic [NODE_W-1:0]  entry_node;
  } in_data_t;

endpackage

`default_nettype wire

### hdl/qhd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module qhd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 340,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/quaternary_huffman_decoder.sv
// Quaternary Huffman decoder top level: node table RAM, lookup sequencer, output stage.
// A data byte makes one table read per decoded digit, up to four, in order (each read needs
// the prior read's node); a load is written as it is accepted; a new request is taken once
// the current byte's digits are all issued. A symbol waits in the hold stage to learn if it
// ends its byte, then moves to the output register. Synchronous reset (rst_n low) sets the
// root node and clears the digit count and total_digits; the node table RAM is not cleared.
`default_nettype none

module quaternary_huffman_decoder #(
  parameter int INNER_NODES = qhd_pkg::INNER_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input requests.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_node[6:0], entry_digit[8:7], entry_is_leaf[9], entry_next[16:10],
  // entry_value[24:17], data_byte[32:25], zero fill [39:33]
  input  logic [qhd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type[0]
  input  logic                             in_tuser,
  // Decoded symbols.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // symbol[7:0]
  output logic [qhd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  // stream_done[0]
  output logic                             out_tuser,
  // total_digits register write.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qhd_pkg::CNT_W-1:0]        cfg_data
);

  import qhd_pkg::*;

  localparam int DEPTH  = INNER_NODES * 4;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [NODE_W-1:0] ROOT  = NODE_W'(INNER_NODES - 1);
  localparam logic [NODE_W-1:0] LIMIT = NODE_W'(INNER_NODES);

  // Architectural state.
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [CNT_W-1:0]   digits_done_r, digits_done_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;

  // Digit sequencer.
  logic [1:0]         rem_r, rem_nxt;
  logic [5:0]         byte_r, byte_nxt;
  logic               look_v_r, look_v_nxt;
  logic               look_last_r, look_last_nxt;
  logic               look_done_r, look_done_nxt;

  // Symbol held until it is known whether it ends its byte.
  logic               hold_v_r, hold_v_nxt;
  logic               hold_fin_r, hold_fin_nxt;
  logic               hold_done_r, hold_done_nxt;
  logic [SYM_W-1:0]   hold_sym_r, hold_sym_nxt;

  // Output register and skid stage.
  logic               out_v_r, out_v_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_done_r, out_done_nxt;
  logic               skid_v_r, skid_v_nxt;
  logic [SYM_W-1:0]   skid_sym_r, skid_sym_nxt;
  logic               skid_last_r, skid_last_nxt;
  logic               skid_done_r, skid_done_nxt;

  in_data_t           in_f;
  entry_t             rd_entry, wr_entry;
  logic [$bits(entry_t)-1:0] rd_word;
  logic [NODE_W+DIGIT_W-1:0] wr_full, rd_full;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               wr_en;
  logic [NODE_W-1:0]  rd_node, cur_node;
  logic [DIGIT_W-1:0] digit;
  logic               adv, in_fire, data_fire, start, cont, issue;
  logic               more;
  logic [CNT_W-1:0]   left, done_inc;
  logic [2:0]         cnt;
  logic               emit, emit_last, leaf;

  assign in_f      = in_data_t'(in_tdata);
  assign rd_entry  = entry_t'(rd_word);
  assign cfg_ready = 1'b1;

  // The engine freezes while the skid stage holds a symbol.
  assign adv       = !skid_v_r;
  assign in_tready = adv && (rem_r == 2'd0);
  assign in_fire   = in_tvalid && in_tready;
  assign data_fire = in_fire && (in_tuser == REQ_DATA);

  // Table load: out-of-range nodes are dropped, out-of-range successors become the root.
  always_comb begin
    wr_entry.leaf  = in_f.entry_is_leaf;
    wr_entry.next  = (in_f.entry_next < LIMIT) ? in_f.entry_next : ROOT;
    wr_entry.value = in_f.entry_value;
  end
  assign wr_en   = in_fire && (in_tuser == REQ_LOAD) && (in_f.entry_node < LIMIT);
  assign wr_full = {in_f.entry_node, in_f.entry_digit};
  assign wr_addr = wr_full[ADDR_W-1:0];

  // Current node, forwarded from the lookup that returns this cycle.
  assign rd_node  = (rd_entry.next < LIMIT) ? rd_entry.next : ROOT;
  assign cur_node = look_v_r ? rd_node : node_r;
  assign leaf     = rd_entry.leaf;

  // Digits left in the stream, capped at four per byte.
  assign more     = digits_done_r < total_r;
  assign left     = total_r - digits_done_r;
  always_comb begin
    priority if (!more) begin
      cnt = 3'd0;
    end else if (|left[CNT_W-1:2]) begin
      cnt = 3'd4;
    end else begin
      cnt = left[2:0];
    end
  end

  // Lookup issue: continue the current byte or start a new one.
  assign cont     = adv && (rem_r != 2'd0);
  assign start    = data_fire && (cnt != 3'd0);
  assign issue    = cont || start;
  assign digit    = cont ? byte_r[1:0] : in_f.data_byte[1:0];
  assign rd_full  = {cur_node, digit};
  assign rd_addr  = rd_full[ADDR_W-1:0];
  assign done_inc = digits_done_r + CNT_W'(1);

  // A held symbol leaves once a later leaf or the end of its byte is seen.
  assign emit      = adv && hold_v_r && (hold_fin_r || (look_v_r && (leaf || look_last_r)));
  assign emit_last = hold_fin_r || (look_v_r && look_last_r && !leaf);

  // Next-state logic.
  always_comb begin
    node_nxt        = node_r;
    digits_done_nxt = digits_done_r;
    total_nxt       = total_r;
    rem_nxt         = rem_r;
    byte_nxt        = byte_r;
    look_v_nxt      = look_v_r;
    look_last_nxt   = look_last_r;
    look_done_nxt   = look_done_r;
    hold_v_nxt      = hold_v_r;
    hold_fin_nxt    = hold_fin_r;
    hold_done_nxt   = hold_done_r;
    hold_sym_nxt    = hold_sym_r;

    if (cfg_valid && cfg_ready) begin
      total_nxt = cfg_data;
    end

    if (adv) begin
      node_nxt   = cur_node;
      look_v_nxt = issue;
      if (issue) begin
        digits_done_nxt = done_inc;
        look_done_nxt   = (done_inc == total_r);
      end
      if (cont) begin
        rem_nxt       = rem_r - 2'd1;
        byte_nxt      = {2'b00, byte_r[5:2]};
        look_last_nxt = (rem_r == 2'd1);
      end else if (start) begin
        rem_nxt       = 2'(cnt - 3'd1);
        byte_nxt      = in_f.data_byte[7:2];
        look_last_nxt = (cnt == 3'd1);
      end

      // Hold stage update.
      if (look_v_r && leaf) begin
        hold_v_nxt    = 1'b1;
        hold_fin_nxt  = look_last_r;
        hold_done_nxt = look_done_r;
        hold_sym_nxt  = rd_entry.value;
      end else if (emit) begin
        hold_v_nxt = 1'b0;
      end
    end
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_v_nxt     = out_v_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    skid_v_nxt    = skid_v_r;
    skid_sym_nxt  = skid_sym_r;
    skid_last_nxt = skid_last_r;
    skid_done_nxt = skid_done_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt    = 1'b1;
        out_sym_nxt  = skid_sym_r;
        out_last_nxt = skid_last_r;
        out_done_nxt = skid_done_r;
        skid_v_nxt   = 1'b0;
      end else begin
        out_v_nxt    = emit;
        out_sym_nxt  = hold_sym_r;
        out_last_nxt = emit_last;
        out_done_nxt = hold_done_r;
      end
    end else if (emit) begin
      skid_v_nxt    = 1'b1;
      skid_sym_nxt  = hold_sym_r;
      skid_last_nxt = emit_last;
      skid_done_nxt = hold_done_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r        <= ROOT;
      digits_done_r <= '0;
      total_r       <= '0;
      rem_r         <= 2'd0;
      look_v_r      <= 1'b0;
      hold_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
      skid_v_r      <= 1'b0;
    end else begin
      node_r        <= node_nxt;
      digits_done_r <= digits_done_nxt;
      total_r       <= total_nxt;
      rem_r         <= rem_nxt;
      look_v_r      <= look_v_nxt;
      hold_v_r      <= hold_v_nxt;
      out_v_r       <= out_v_nxt;
      skid_v_r      <= skid_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    look_last_r <= look_last_nxt;
    look_done_r <= look_done_nxt;
    hold_fin_r  <= hold_fin_nxt;
    hold_done_r <= hold_done_nxt;
    hold_sym_r  <= hold_sym_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
    skid_sym_r  <= skid_sym_nxt;
    skid_last_r <= skid_last_nxt;
    skid_done_r <= skid_done_nxt;
  end

  // Node table; the read data holds while the engine is frozen.
  qhd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

`default_nettype wire

### hdl/qhd_checker.sv
// Port-level checker for the quaternary Huffman decoder, bound to the top level.
`default_nettype none

module qhd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [qhd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [qhd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [qhd_pkg::CNT_W-1:0]       cfg_data
);

  // Reset empties the output side.
  a_reset_out_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("symbol offered right after reset");

  // Reset leaves the decoder ready for a request.
  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // A stalled symbol stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("symbol withdrawn while stalled");

  // A stalled symbol keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("symbol payload changed while stalled");

endmodule

bind quaternary_huffman_decoder qhd_checker u_qhd_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the quaternary Huffman decoder: table loads, data requests, digit limits.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qhd_pkg::*;

  localparam int          NODES         = INNER_NODES_DEF;
  localparam logic [6:0]  ROOT          = 7'(NODES - 1);
  localparam int          PERIOD        = 10;
  localparam int          RESET_CYCLES  = 11;
  localparam int          SETTLE_CYCLES = 32;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RANDOM_ITEMS  = 380;
  localparam int          IDLE_PERCENT  = 30;

  // One decoded symbol as it should leave the result channel.
  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done;
  } symbol_t;

  // Tracks the decoder state and the queue of symbols still to come.
  class decode_scoreboard;
    entry_t           node_table [NODES*4];
    logic [NODE_W-1:0] current_node;
    logic [CNT_W-1:0] digits_done;
    logic [CNT_W-1:0] total_digits;
    symbol_t          expected_symbols [$];
    int               errors;

    function new();
      foreach (node_table[i]) node_table[i] = '0;
      current_node = ROOT;
      digits_done  = '0;
      total_digits = '0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction

    function void set_total(logic [CNT_W-1:0] value);
      total_digits = value;
    endfunction

    // Walks the tree for up to four digits of one data byte.
    function void decode_byte(logic [SYM_W-1:0] data);
      symbol_t         run [4];
      int              found;
      int              count;
      logic [CNT_W-1:0] left;
      entry_t          e;
      logic [1:0]      digit;
      if (digits_done >= total_digits) return;
      left  = total_digits - digits_done;
      count = (left < 32'd4) ? int'(left) : 4;
      found = 0;
      for (int j = 0; j < count; j++) begin
        digit = data[2*j +: 2];
        e = node_table[int'(current_node) * 4 + int'(digit)];
        digits_done++;
        if (e.leaf) begin
          run[found].symbol = e.value;
          run[found].last   = 1'b0;
          run[found].done   = (digits_done == total_digits);
          found++;
        end
        current_node = e.next;
      end
      for (int k = 0; k < found; k++) begin
        run[k].last = (k == found - 1);
        expected_symbols.insert(expected_symbols.size(), run[k]);
      end
    endfunction

    // Applies one accepted input request to the predicted state.
    function void note_request(logic kind, logic [IN_TDATA_W-1:0] word);
      in_data_t w;
      entry_t   e;
      w = in_data_t'(word);
      if (kind == REQ_DATA) begin
        decode_byte(w.data_byte);
      end else if (int'(w.entry_node) < NODES) begin
        e.leaf  = w.entry_is_leaf;
        e.next  = (int'(w.entry_next) < NODES) ? w.entry_next : ROOT;
        e.value = w.entry_value;
        node_table[int'(w.entry_node) * 4 + int'(w.entry_digit)] = e;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compares one accepted symbol with the oldest one expected.
    task check_symbol(logic [SYM_W-1:0] symbol, logic last, logic done);
      symbol_t want;
      if (expected_symbols.size() == 0) begin
        report($sformatf("symbol %02h arrived with none expected", symbol));
        return;
      end
      want = expected_symbols.pop_front();
      if (symbol !== want.symbol)
        report($sformatf("symbol %02h, expected %02h", symbol, want.symbol));
      if (last !== want.last)
        report($sformatf("tlast %b, expected %b on symbol %02h", last, want.last, want.symbol));
      if (done !== want.done)
        report($sformatf("stream_done %b, expected %b on symbol %02h", done, want.done,
                         want.symbol));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data;

  decode_scoreboard sb;

  // Handshake between the sender and the receiver for the pressure tests.
  bit hold_req;
  bit hold_done;
  bit calm;

  // Nodes whose four entries are written and point only into this set.
  bit in_tree [NODES];
  int tree_nodes [$];

  quaternary_huffman_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #(2_000_000);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] load_word(logic [6:0] node, logic [1:0] digit,
                                                       logic leaf, logic [6:0] next,
                                                       logic [7:0] value);
    in_data_t w;
    w.pad           = '0;
    w.data_byte     = 8'($urandom);
    w.entry_value   = value;
    w.entry_next    = next;
    w.entry_is_leaf = leaf;
    w.entry_digit   = digit;
    w.entry_node    = node;
    return w;
  endfunction

  // Data requests carry random noise in the unused entry fields.
  function automatic logic [IN_TDATA_W-1:0] data_word(logic [7:0] data);
    in_data_t    w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w = in_data_t'(r[IN_TDATA_W-1:0]);
    w.pad       = '0;
    w.data_byte = data;
    return w;
  endfunction

  // Offers one request, with a random gap in front, and waits for acceptance.
  task automatic send_request(logic kind, logic [IN_TDATA_W-1:0] word);
    while (!calm && !(hold_req && !hold_done) && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sb.note_request(kind, word);
  endtask

  task automatic send_load(logic [6:0] node, logic [1:0] digit, logic leaf, logic [6:0] next,
                           logic [7:0] value);
    send_request(REQ_LOAD, load_word(node, digit, leaf, next, value));
  endtask

  task automatic send_data(logic [7:0] data);
    send_request(REQ_DATA, data_word(data));
  endtask

  // Stops sending until every symbol is in and the block has gone quiet.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_total(value);
  endtask

  // Next node for a new entry: a finished node, or now and then an out-of-range one.
  function automatic logic [6:0] pick_target();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(NODES, 127));
    return 7'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]);
  endfunction

  // Writes all four entries of a fresh node, then makes it reachable.
  task automatic grow_tree();
    int         node;
    logic [1:0] digit;
    do node = $urandom_range(0, NODES - 1); while (in_tree[node]);
    digit = 2'($urandom);
    for (int k = 0; k < 4; k++) begin
      send_load(7'(node), digit, 1'($urandom), pick_target(), 8'($urandom));
      digit = digit + 2'd1;
    end
    in_tree[node] = 1'b1;
    tree_nodes.insert(tree_nodes.size(), node);
  endtask

  // One random stimulus step; returns how many requests it sent.
  task automatic random_item(output int sent);
    int pick;
    pick = $urandom_range(0, 99);
    sent = 1;
    if (pick < 65) begin
      send_data(8'($urandom));
    end else if (pick < 73) begin
      // Loads aimed past the last node are dropped by the block.
      send_load(7'($urandom_range(NODES, 127)), 2'($urandom), 1'($urandom), 7'($urandom),
                8'($urandom));
    end else if (pick < 80 && tree_nodes.size() < NODES) begin
      grow_tree();
      sent = 4;
    end else begin
      send_load(7'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]), 2'($urandom),
                1'($urandom), pick_target(), 8'($urandom));
    end
  endtask

  // Picks a digit limit relative to what has been decoded so far.
  function automatic logic [CNT_W-1:0] pick_total();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '1;
    if (pick < 20) return $urandom_range(0, sb.digits_done);
    if (pick < 45) return sb.digits_done + $urandom_range(1, 7);
    return sb.digits_done + $urandom_range(8, 200);
  endfunction

  // Result side: random back-pressure, one long hold-off, and checking.
  initial begin : receiver
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_symbol(out_tdata, out_tlast, out_tuser);
      if (hold_req && !hold_done && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Request side: reset, directed requests, then random phases.
  initial begin
    int sent;
    int len;
    int n;
    int step;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = REQ_LOAD;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    calm      = 1'b0;
    foreach (in_tree[i]) in_tree[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Limit of zero: loads still land, a data byte decodes nothing.
    write_total('0);
    send_load(7'd0, 2'd0, 1'b1, ROOT, 8'hA5);
    send_load(7'd0, 2'd1, 1'b1, 7'd127, 8'h5A);
    send_load(7'd0, 2'd2, 1'b0, ROOT, 8'h00);
    send_load(7'd0, 2'd3, 1'b1, 7'd0, 8'h01);
    send_load(ROOT, 2'd0, 1'b1, ROOT, 8'h00);
    send_load(ROOT, 2'd1, 1'b1, 7'd100, 8'hFF);
    send_load(ROOT, 2'd2, 1'b0, ROOT, 8'h3C);
    send_load(ROOT, 2'd3, 1'b0, 7'd0, 8'hC3);
    send_load(7'd127, 2'd3, 1'b1, 7'd127, 8'hFF);
    send_load(7'(NODES), 2'd0, 1'b0, 7'd0, 8'h00);
    send_data(8'hFF);
    in_tree[0]    = 1'b1;
    in_tree[ROOT] = 1'b1;
    tree_nodes.insert(tree_nodes.size(), int'(ROOT));
    tree_nodes.insert(tree_nodes.size(), 0);

    // Six digits: the second byte is cut short and the third is past the end.
    wait_quiet();
    write_total(32'd6);
    send_data(8'h00);
    send_data(8'hE4);
    send_data(8'h55);

    // Largest limit, written after the stream had finished.
    wait_quiet();
    write_total('1);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'hAA);
    send_data(8'h1B);
    send_data(8'hE4);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_quiet();
      write_total(pick_total());
      len  = $urandom_range(8, 50);
      calm = (sent >= 260 && sent < 340);
      // A long phase under a receiver hold-off fills the block up.
      if (!hold_req && sent >= 120) begin
        hold_req = 1'b1;
        len      = 60;
      end
      n = 0;
      while (n < len) begin
        random_item(step);
        n += step;
      end
      sent += n;
    end
    calm = 1'b0;

    wait_quiet();
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
